[hdl/ppe_pkg.sv]
package ppe_pkg;

    localparam int POOL_SLOTS_DEF = 1024;
    localparam int SINE_STEPS_DEF = 1024;

    localparam int OUT_W = 176;
    localparam int IN_W  = 16;

    localparam logic [31:0] LFSR_SEED = 32'h1D87_2B41;
    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

    // register indexes
    localparam logic [2:0] REG_EMIT_ANGLES  = 3'd0;
    localparam logic [2:0] REG_EMIT_SPEED   = 3'd1;
    localparam logic [2:0] REG_START_COLOR  = 3'd2;
    localparam logic [2:0] REG_START_SPREAD = 3'd3;
    localparam logic [2:0] REG_END_COLOR    = 3'd4;
    localparam logic [2:0] REG_END_SPREAD   = 3'd5;
    localparam logic [2:0] REG_FORCE        = 3'd6;
    localparam logic [2:0] REG_LIFE_LIMITS  = 3'd7;

    localparam logic [31:0] EMIT_SPEED_RST  = 32'd256;
    localparam logic [47:0] LIFE_LIMITS_RST = 48'h0400_0000_003C;

    // result status codes
    localparam logic [1:0] STAT_SPAWNED = 2'd0;
    localparam logic [1:0] STAT_UPDATED = 2'd1;
    localparam logic [1:0] STAT_FREED   = 2'd2;
    localparam logic [1:0] STAT_REJECT  = 2'd3;

    // datapath operations
    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_LATCH    = 4'd1;
    localparam logic [3:0] OP_SP_CHK   = 4'd2;
    localparam logic [3:0] OP_UPD      = 4'd3;
    localparam logic [3:0] OP_POP      = 4'd4;
    localparam logic [3:0] OP_DRAW     = 4'd5;
    localparam logic [3:0] OP_SIN      = 4'd6;
    localparam logic [3:0] OP_MUL      = 4'd7;
    localparam logic [3:0] OP_DIV_GO   = 4'd8;
    localparam logic [3:0] OP_DIV_WAIT = 4'd9;
    localparam logic [3:0] OP_WR       = 4'd10;
    localparam logic [3:0] OP_LOAD     = 4'd11;

    typedef struct packed {
        logic [3:0] op;
        logic [3:0] idx;
    } t_cmd;

    typedef struct packed {
        logic spawn;
        logic reject;
        logic div_done;
        logic out_free;
    } t_sts;

    // sine of a binary angle, signed q1.14, quarter-wave plus odd series in q30
    function automatic logic signed [15:0] sine_q(input int unsigned q);
        longint unsigned w;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned one;
        int unsigned quad;
        int r;
        quad = (q >> 14) & 3;
        w    = longint'(q & 32'h3FFF);
        if ((quad & 1) != 0) w = 64'd16384 - w;
        one = 64'd1 << 30;
        x   = (w * 64'd1686629713) >> 14;
        x2  = (x * x) >> 30;
        t   = one - x2 / 72;
        t   = one - ((x2 * t) >> 30) / 42;
        t   = one - ((x2 * t) >> 30) / 20;
        t   = one - ((x2 * t) >> 30) / 6;
        s   = (x * t) >> 30;
        r   = int'((s + 64'd32768) >> 16);
        return ((quad & 2) != 0) ? 16'(-r) : 16'(r);
    endfunction

endpackage

[hdl/particle_pool_engine.sv]
// particle pool engine: one emitter over a pool of particle slots, one word at a time
// update word: latched, decoded, slot updated, result loaded; then the next word is accepted
// spawn word: reject check and, if not rejected, a slot pop, ten serial draws,
//   four sine lookups, five shared products, three divisions and the slot write
// a result still waiting in the output register holds off the next load by its stall
// reset (synchronous, active low) restores registers, free stack mark, counters and seed
module particle_pool_engine
    import ppe_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    parameter int SINE_STEPS = SINE_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input words
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // [9:0] slot_index, rest zero
    input  logic [0:0]       s_axis_tuser,   // [0] opcode: 0 spawn, 1 update
    // result words
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // result_slot, pos_x/y/z, old_pos_x/y/z,
                                             // color_r/g/b, life_left, zero fill
    output logic [1:0]       m_axis_tuser,   // [1:0] status
    // register writes
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: one word at a time, steps the datapath through each phase
    ppe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath: slot store, free stack, lfsr, sine table, multiplier, divider,
    // output register that lets a result wait while the next word is taken
    ppe_dp #(
        .POOL_SLOTS (POOL_SLOTS),
        .SINE_STEPS (SINE_STEPS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_in_opcode (s_axis_tuser[0]),
        .i_in_slot   (s_axis_tdata[9:0]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_user  (m_axis_tuser),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[hdl/ppe_ram.sv]
module ppe_ram
    import ppe_pkg::*;
#(
    parameter int WIDTH = 16,
    parameter int DEPTH = POOL_SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ppe_div.sv]
module ppe_div
    import ppe_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [16:0] i_num,
    input  logic [15:0]        i_den,
    output logic               o_done,
    output logic signed [16:0] o_quot
);

    // restoring division on magnitudes, one quotient bit a cycle
    localparam int DIV_STEPS = 17;

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [16:0] r_mag;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic        r_neg;

    logic [16:0] w_trial;
    logic        w_ge;

    assign w_trial = {r_rem, r_mag[16]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(DIV_STEPS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_num[16] ? 17'(-i_num) : 17'(i_num);
            r_neg <= i_num[16];
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_ge ? 16'(w_trial - {1'b0, r_den}) : w_trial[15:0];
            r_mag <= {r_mag[15:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_mag) : $signed(r_mag);

endmodule

[hdl/ppe_ctrl.sv]
module ppe_ctrl
    import ppe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_UPD    = 4'd2;
    localparam logic [3:0] ST_POP    = 4'd3;
    localparam logic [3:0] ST_DRAW   = 4'd4;
    localparam logic [3:0] ST_SIN    = 4'd5;
    localparam logic [3:0] ST_MUL    = 4'd6;
    localparam logic [3:0] ST_DGO    = 4'd7;
    localparam logic [3:0] ST_DWAIT  = 4'd8;
    localparam logic [3:0] ST_WR     = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic [3:0] LAST_DRAW = 4'd9;
    localparam logic [3:0] LAST_SIN  = 4'd4;
    localparam logic [3:0] LAST_MUL  = 4'd4;
    localparam logic [3:0] LAST_DIV  = 4'd2;

    logic [3:0] r_state, n_state;
    logic [3:0] r_idx, n_idx;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_idx;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.spawn) begin
                    o_cmd.op = OP_SP_CHK;
                    n_state  = i_sts.reject ? ST_OUT : ST_POP;
                end else begin
                    n_state = ST_UPD;
                end
            end
            ST_UPD: begin
                o_cmd.op = OP_UPD;
                n_state  = ST_OUT;
            end
            ST_POP: begin
                o_cmd.op = OP_POP;
                n_idx    = '0;
                n_state  = ST_DRAW;
            end
            ST_DRAW: begin
                o_cmd.op = OP_DRAW;
                if (r_idx == LAST_DRAW) begin
                    n_idx   = '0;
                    n_state = ST_SIN;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_SIN: begin
                o_cmd.op = OP_SIN;
                if (r_idx == LAST_SIN) begin
                    n_idx   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_MUL: begin
                o_cmd.op = OP_MUL;
                if (r_idx == LAST_MUL) begin
                    n_idx   = '0;
                    n_state = ST_DGO;
                end else begin
                    n_idx = r_idx + 4'd1;
                end
            end
            ST_DGO: begin
                o_cmd.op = OP_DIV_GO;
                n_state  = ST_DWAIT;
            end
            ST_DWAIT: begin
                o_cmd.op = OP_DIV_WAIT;
                if (i_sts.div_done) begin
                    if (r_idx == LAST_DIV) begin
                        n_state = ST_WR;
                    end else begin
                        n_idx   = r_idx + 4'd1;
                        n_state = ST_DGO;
                    end
                end
            end
            ST_WR: begin
                o_cmd.op = OP_WR;
                n_state  = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

[hdl/ppe_dp.sv]
module ppe_dp
    import ppe_pkg::*;
#(
    parameter int POOL_SLOTS = POOL_SLOTS_DEF,
    parameter int SINE_STEPS = SINE_STEPS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic             i_in_opcode,
    input  logic [9:0]       i_in_slot,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [63:0]      i_cfg_data,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    output logic [1:0]       o_out_user,
    output logic [OUT_W-1:0] o_out_data
);

    localparam int SW = $clog2(POOL_SLOTS);
    localparam int CW = $clog2(POOL_SLOTS + 1);
    localparam int KW = $clog2(SINE_STEPS);

    // slot word: pos, prior pos, velocity, colour, colour step, life, live
    localparam int POS_O  = 0;
    localparam int PRV_O  = 48;
    localparam int VEL_O  = 96;
    localparam int COL_O  = 144;
    localparam int STP_O  = 192;
    localparam int LIFE_O = 240;
    localparam int LIVE_O = 256;
    localparam int WORD_W = 257;

    function automatic logic signed [15:0] sat16(input logic signed [35:0] v);
        if (v > 36'sd32767) return 16'sh7FFF;
        if (v < -36'sd32768) return 16'sh8000;
        return v[15:0];
    endfunction

    // configuration
    logic [63:0] r_angles;
    logic [31:0] r_speed_cfg;
    logic [47:0] r_st_cfg, r_st_spr, r_en_cfg, r_en_spr, r_force, r_life_lim;

    // pool control
    logic          r_op;
    logic [9:0]    r_slot_in;
    logic [CW-1:0] r_fc;
    logic [CW-1:0] r_low;
    logic [CW-1:0] r_live_cnt;
    logic [31:0]   r_lfsr;
    logic          r_o_valid;

    // spawn working set
    logic [SW-1:0]      r_slot;
    logic [15:0]        r_yaw, r_pitch, r_life;
    logic signed [15:0] r_speed;
    logic signed [15:0] r_st [3];
    logic signed [15:0] r_en [3];
    logic signed [15:0] r_sc [4];
    logic signed [15:0] r_sin_q;
    logic signed [17:0] r_d0, r_d2;
    logic signed [15:0] r_vel [3];
    logic signed [15:0] r_step [3];

    logic [1:0]       r_res_stat;
    logic [OUT_W-1:0] r_res_data;
    logic [1:0]       r_o_user;
    logic [OUT_W-1:0] r_o_data;

    // slot store
    logic [16:0]       w_slot_ext;
    logic              w_in_range;
    logic [SW-1:0]     w_slot_addr;
    logic [CW-1:0]     w_mark;
    logic              w_touched;
    logic [WORD_W-1:0] w_rd;
    logic              w_live_ok;
    logic              w_ram_we;
    logic [SW-1:0]     w_ram_waddr;
    logic [WORD_W-1:0] w_ram_wdata;

    // free stack
    logic [SW-1:0] w_stk_rd;
    logic [SW-1:0] w_stk_raddr;
    logic          w_stk_we;
    logic [SW-1:0] w_pos_top;
    logic [SW-1:0] w_orig;
    logic [SW-1:0] w_pop_slot;
    logic [16:0]   w_orig_ext;

    assign w_slot_ext  = 17'(r_slot_in);
    assign w_in_range  = w_slot_ext < 17'(POOL_SLOTS);
    assign w_slot_addr = w_slot_ext[SW-1:0];
    // slots at or above this mark were never handed out since reset
    assign w_mark      = CW'(POOL_SLOTS) - r_low;
    assign w_touched   = w_slot_ext < 17'(w_mark);
    assign w_live_ok   = w_in_range && w_touched && w_rd[LIVE_O];

    assign w_stk_raddr = SW'(r_fc - CW'(1));
    assign w_pos_top   = r_fc[SW-1:0];
    assign w_orig_ext  = 17'(POOL_SLOTS - 1) - 17'(w_pos_top);
    assign w_orig      = w_orig_ext[SW-1:0];
    assign w_pop_slot  = (r_fc < r_low) ? w_orig : w_stk_rd;

    // update lanes
    logic signed [15:0] w_pos [3], w_prv [3], w_vel [3], w_col [3], w_stp [3], w_frc [3];
    logic signed [15:0] w_npos [3], w_nvel [3], w_ncol [3];
    logic [15:0]        w_life_rd;
    logic               w_free;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_pos[i]  = w_rd[POS_O + 16*i +: 16];
            w_prv[i]  = w_rd[PRV_O + 16*i +: 16];
            w_vel[i]  = w_rd[VEL_O + 16*i +: 16];
            w_col[i]  = w_rd[COL_O + 16*i +: 16];
            w_stp[i]  = w_rd[STP_O + 16*i +: 16];
            w_frc[i]  = r_force[16*i +: 16];
            w_npos[i] = sat16(36'(w_pos[i]) + 36'(w_vel[i]));
            w_nvel[i] = sat16(36'(w_vel[i]) + 36'(w_frc[i]));
            w_ncol[i] = sat16(36'(w_col[i]) + 36'(w_stp[i]));
        end
    end

    assign w_life_rd = w_rd[LIFE_O +: 16];
    assign w_free    = w_life_rd == 16'd0;

    always_comb begin
        w_ram_we    = 1'b0;
        w_ram_waddr = w_slot_addr;
        w_ram_wdata = w_rd;
        if (i_cmd.op == OP_UPD && w_live_ok) begin
            w_ram_we = 1'b1;
            if (w_free) begin
                w_ram_wdata[LIVE_O] = 1'b0;
            end else begin
                w_ram_wdata = {1'b1, w_life_rd - 16'd1, w_rd[STP_O +: 48],
                               w_ncol[2], w_ncol[1], w_ncol[0],
                               w_nvel[2], w_nvel[1], w_nvel[0],
                               w_pos[2], w_pos[1], w_pos[0],
                               w_npos[2], w_npos[1], w_npos[0]};
            end
        end else if (i_cmd.op == OP_WR) begin
            w_ram_we    = 1'b1;
            w_ram_waddr = r_slot;
            w_ram_wdata = {1'b1, r_life, r_step[2], r_step[1], r_step[0],
                           r_st[2], r_st[1], r_st[0],
                           r_vel[2], r_vel[1], r_vel[0], 96'd0};
        end
    end

    assign w_stk_we = (i_cmd.op == OP_UPD) && w_live_ok && w_free
                      && (r_fc < CW'(POOL_SLOTS));

    ppe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POOL_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_slot_addr),
        .o_rdata (w_rd)
    );

    ppe_ram #(
        .WIDTH (SW),
        .DEPTH (POOL_SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk_we),
        .i_waddr (w_pos_top),
        .i_wdata (w_slot_addr),
        .i_raddr (w_stk_raddr),
        .o_rdata (w_stk_rd)
    );

    // random draw and jitter, one multiplier shared by all ten draws
    logic [31:0]        w_lfsr_n;
    logic signed [9:0]  w_rnd;
    logic signed [16:0] w_j_base, w_j_spr;
    logic               w_j_trunc;
    logic signed [26:0] w_j_prod;
    logic signed [18:0] w_j_sh;
    logic signed [19:0] w_j_sum;
    logic signed [15:0] w_j_sat;
    logic [15:0]        w_j_life;

    assign w_lfsr_n = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_TAPS : 32'd0);
    assign w_rnd    = $signed({1'b0, w_lfsr_n[8:0]}) - 10'sd256;

    always_comb begin
        w_j_trunc = 1'b0;
        case (i_cmd.idx)
            4'd0: begin
                w_j_base = $signed({1'b0, r_angles[15:0]});
                w_j_spr  = $signed({1'b0, r_angles[47:32]});
            end
            4'd1: begin
                w_j_base = $signed({1'b0, r_angles[31:16]});
                w_j_spr  = $signed({1'b0, r_angles[63:48]});
            end
            4'd2: begin
                w_j_base = 17'($signed(r_speed_cfg[15:0]));
                w_j_spr  = 17'($signed(r_speed_cfg[31:16]));
            end
            4'd3: begin
                w_j_base = 17'($signed(r_st_cfg[15:0]));
                w_j_spr  = 17'($signed(r_st_spr[15:0]));
            end
            4'd4: begin
                w_j_base = 17'($signed(r_st_cfg[31:16]));
                w_j_spr  = 17'($signed(r_st_spr[31:16]));
            end
            4'd5: begin
                w_j_base = 17'($signed(r_st_cfg[47:32]));
                w_j_spr  = 17'($signed(r_st_spr[47:32]));
            end
            4'd6: begin
                w_j_base = 17'($signed(r_en_cfg[15:0]));
                w_j_spr  = 17'($signed(r_en_spr[15:0]));
            end
            4'd7: begin
                w_j_base = 17'($signed(r_en_cfg[31:16]));
                w_j_spr  = 17'($signed(r_en_spr[31:16]));
            end
            4'd8: begin
                w_j_base = 17'($signed(r_en_cfg[47:32]));
                w_j_spr  = 17'($signed(r_en_spr[47:32]));
            end
            default: begin
                // life: unsigned base and spread, product truncated toward zero
                w_j_base  = $signed({1'b0, r_life_lim[15:0]});
                w_j_spr   = $signed({1'b0, r_life_lim[31:16]});
                w_j_trunc = 1'b1;
            end
        endcase
        w_j_prod = w_j_spr * w_rnd;
        if (w_j_trunc && w_j_prod[26]) begin
            w_j_sh = 19'((w_j_prod + 27'sd255) >>> 8);
        end else begin
            w_j_sh = 19'(w_j_prod >>> 8);
        end
        w_j_sum = 20'(w_j_base) + 20'(w_j_sh);
        w_j_sat = sat16(36'(w_j_sum));
        if (w_j_sum < 20'sd1) begin
            w_j_life = 16'd1;
        end else if (w_j_sum > 20'sd65535) begin
            w_j_life = 16'hFFFF;
        end else begin
            w_j_life = w_j_sum[15:0];
        end
    end

    // sine table, one registered lookup a cycle
    logic signed [15:0] w_sin_tab [SINE_STEPS];
    logic [15:0]        w_sin_ang;
    logic [28:0]        w_sin_kp;
    logic [KW-1:0]      w_sin_k;

    for (genvar gk = 0; gk < SINE_STEPS; gk++) begin : g_sin_tab
        localparam int unsigned QA = (gk * 65536) / SINE_STEPS;
        assign w_sin_tab[gk] = sine_q(QA);
    end

    always_comb begin
        case (i_cmd.idx)
            4'd1:    w_sin_ang = r_yaw + 16'h4000;
            4'd2:    w_sin_ang = r_pitch;
            4'd3:    w_sin_ang = r_pitch + 16'h4000;
            default: w_sin_ang = r_yaw;
        endcase
    end

    assign w_sin_kp = 29'(w_sin_ang) * 29'(SINE_STEPS);
    assign w_sin_k  = w_sin_kp[16 +: KW];

    // direction and velocity products; sc holds sin yaw, cos yaw, sin pitch, cos pitch
    logic signed [17:0] w_m_a;
    logic signed [16:0] w_m_b;
    logic signed [34:0] w_m_p;
    logic signed [34:0] w_m_sh;

    always_comb begin
        case (i_cmd.idx)
            4'd0: begin
                w_m_a = -18'(r_sc[0]);
                w_m_b = 17'(r_sc[3]);
            end
            4'd1: begin
                w_m_a = 18'(r_sc[3]);
                w_m_b = 17'(r_sc[1]);
            end
            4'd2: begin
                w_m_a = r_d0;
                w_m_b = 17'(r_speed);
            end
            4'd3: begin
                w_m_a = 18'(r_sc[2]);
                w_m_b = 17'(r_speed);
            end
            default: begin
                w_m_a = r_d2;
                w_m_b = 17'(r_speed);
            end
        endcase
        w_m_p  = w_m_a * w_m_b;
        w_m_sh = w_m_p >>> 14;
    end

    // colour step division
    logic               w_div_start;
    logic               w_div_done;
    logic signed [16:0] w_div_num;
    logic signed [16:0] w_div_quot;
    logic [1:0]         w_lane;

    assign w_lane      = i_cmd.idx[1:0];
    assign w_div_start = i_cmd.op == OP_DIV_GO;
    assign w_div_num   = 17'(r_en[w_lane]) - 17'(r_st[w_lane]);

    ppe_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_life),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    // status back to the controller
    assign o_sts.spawn    = !r_op;
    assign o_sts.reject   = (r_fc == '0) || (17'(r_live_cnt) >= 17'(r_life_lim[47:32]));
    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_o_valid || i_out_ready;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angles    <= '0;
            r_speed_cfg <= EMIT_SPEED_RST;
            r_st_cfg    <= '0;
            r_st_spr    <= '0;
            r_en_cfg    <= '0;
            r_en_spr    <= '0;
            r_force     <= '0;
            r_life_lim  <= LIFE_LIMITS_RST;
            r_fc        <= CW'(POOL_SLOTS);
            r_low       <= CW'(POOL_SLOTS);
            r_live_cnt  <= '0;
            r_lfsr      <= LFSR_SEED;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_EMIT_ANGLES:  r_angles    <= i_cfg_data;
                    REG_EMIT_SPEED:   r_speed_cfg <= i_cfg_data[31:0];
                    REG_START_COLOR:  r_st_cfg    <= i_cfg_data[47:0];
                    REG_START_SPREAD: r_st_spr    <= i_cfg_data[47:0];
                    REG_END_COLOR:    r_en_cfg    <= i_cfg_data[47:0];
                    REG_END_SPREAD:   r_en_spr    <= i_cfg_data[47:0];
                    REG_FORCE:        r_force     <= i_cfg_data[47:0];
                    REG_LIFE_LIMITS:  r_life_lim  <= i_cfg_data[47:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_SP_CHK && !o_sts.reject) begin
                r_fc <= r_fc - CW'(1);
            end
            if (i_cmd.op == OP_POP && r_fc < r_low) begin
                r_low <= r_fc;
            end
            if (i_cmd.op == OP_DRAW) begin
                r_lfsr <= w_lfsr_n;
            end
            if (i_cmd.op == OP_WR) begin
                r_live_cnt <= r_live_cnt + CW'(1);
            end
            if (i_cmd.op == OP_UPD && w_live_ok && w_free) begin
                if (r_fc < CW'(POOL_SLOTS)) r_fc <= r_fc + CW'(1);
                if (r_live_cnt != '0) r_live_cnt <= r_live_cnt - CW'(1);
            end
            if (i_cmd.op == OP_LOAD) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_sin_q <= w_sin_tab[w_sin_k];
        case (i_cmd.op)
            OP_LATCH: begin
                r_op      <= i_in_opcode;
                r_slot_in <= i_in_slot;
            end
            OP_SP_CHK: begin
                r_res_stat <= STAT_REJECT;
                r_res_data <= '0;
            end
            OP_UPD: begin
                if (!w_live_ok) begin
                    r_res_stat <= STAT_REJECT;
                    r_res_data <= {166'd0, r_slot_in};
                end else if (w_free) begin
                    r_res_stat <= STAT_FREED;
                    r_res_data <= {6'd0, 16'd0, w_col[2], w_col[1], w_col[0],
                                   w_prv[2], w_prv[1], w_prv[0],
                                   w_pos[2], w_pos[1], w_pos[0], r_slot_in};
                end else begin
                    r_res_stat <= STAT_UPDATED;
                    r_res_data <= {6'd0, w_life_rd - 16'd1,
                                   w_ncol[2], w_ncol[1], w_ncol[0],
                                   w_pos[2], w_pos[1], w_pos[0],
                                   w_npos[2], w_npos[1], w_npos[0], r_slot_in};
                end
            end
            OP_POP: begin
                r_slot <= w_pop_slot;
            end
            OP_DRAW: begin
                case (i_cmd.idx)
                    4'd0:    r_yaw   <= w_j_sum[15:0];
                    4'd1:    r_pitch <= w_j_sum[15:0];
                    4'd2:    r_speed <= w_j_sat;
                    4'd3:    r_st[0] <= w_j_sat;
                    4'd4:    r_st[1] <= w_j_sat;
                    4'd5:    r_st[2] <= w_j_sat;
                    4'd6:    r_en[0] <= w_j_sat;
                    4'd7:    r_en[1] <= w_j_sat;
                    4'd8:    r_en[2] <= w_j_sat;
                    default: r_life  <= w_j_life;
                endcase
            end
            OP_SIN: begin
                if (i_cmd.idx != 4'd0) begin
                    r_sc[2'(i_cmd.idx - 4'd1)] <= r_sin_q;
                end
            end
            OP_MUL: begin
                case (i_cmd.idx)
                    4'd0:    r_d0     <= w_m_sh[17:0];
                    4'd1:    r_d2     <= w_m_sh[17:0];
                    4'd2:    r_vel[0] <= sat16(36'(w_m_sh));
                    4'd3:    r_vel[1] <= sat16(36'(w_m_sh));
                    default: r_vel[2] <= sat16(36'(w_m_sh));
                endcase
            end
            OP_DIV_WAIT: begin
                if (w_div_done) begin
                    r_step[w_lane] <= sat16(36'(w_div_quot));
                end
            end
            OP_WR: begin
                r_res_stat <= STAT_SPAWNED;
                r_res_data <= {6'd0, r_life, r_st[2], r_st[1], r_st[0], 96'd0,
                               10'(17'(r_slot))};
            end
            OP_LOAD: begin
                r_o_user <= r_res_stat;
                r_o_data <= r_res_data;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_o_valid;
    assign o_out_user  = r_o_user;
    assign o_out_data  = r_o_data;

endmodule
